// ===== rtl/hrcd_pkg.sv =====
// hrcd_pkg: word types, character constants and the header name pattern
// for the http request completeness detector; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hrcd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_request;
    } in_word_t;

    typedef struct packed {
        logic        header_done;
        logic        request_complete;
        logic [15:0] body_length;
        logic [15:0] header_length;
        logic [15:0] bytes_seen;
        logic        overflow;
    } out_word_t;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_Z   = 8'h5A;

    localparam logic [3:0] NAME_LEN = 4'd15;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // lower-case header name "content-length:"
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hrcd_in_if.sv =====
// hrcd_in_if: valid/ready channel carrying request byte words
// depends on hrcd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hrcd_in_if;
    logic              valid;
    logic              ready;
    hrcd_pkg::in_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== rtl/hrcd_out_if.sv =====
// hrcd_out_if: valid/ready channel carrying framing status words
// depends on hrcd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hrcd_out_if;
    logic               valid;
    logic               ready;
    hrcd_pkg::out_word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== rtl/http_request_completeness_detector.sv =====
// http_request_completeness_detector: byte-wise http header framing with content-length
// depends on hrcd_pkg, hrcd_in_if, hrcd_out_if
// output: each accepted byte's status word is registered in the output register
// throughput: one byte per cycle; the input stalls only while the output word is not taken
// reset: parse state cleared, no word held, capacity set to BUFFER_BYTES - 1
`timescale 1ns / 1ps
`default_nettype none

module http_request_completeness_detector #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    hrcd_in_if.sink          in_ch,
    hrcd_out_if.source       out_ch,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam logic [15:0] CAPACITY_RESET = 16'((BUFFER_BYTES - 1) & 16'hFFFF);

    localparam logic [1:0] PHASE_NAME  = 2'd0;
    localparam logic [1:0] PHASE_BLANK = 2'd1;
    localparam logic [1:0] PHASE_DIGIT = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    localparam logic [1:0] END_NONE = 2'd0;
    localparam logic [1:0] END_CR   = 2'd1;
    localparam logic [1:0] END_CRLF = 2'd2;
    localparam logic [1:0] END_CRLFCR = 2'd3;

    logic [15:0] capacity_reg;

    logic [1:0]  end_prog_reg,  end_prog_next;
    logic        hdr_fin_reg,   hdr_fin_next;
    logic        line_start_reg, line_start_next;
    logic [3:0]  name_idx_reg,  name_idx_next;
    logic        name_dead_reg, name_dead_next;
    logic [1:0]  phase_reg,     phase_next;
    logic [15:0] len_acc_reg,   len_acc_next;
    logic [15:0] byte_cnt_reg,  byte_cnt_next;
    logic [15:0] hdr_size_reg,  hdr_size_next;

    logic                out_valid_reg;
    hrcd_pkg::out_word_t out_word_reg, out_word_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  low;
    logic        is_digit;
    logic        prev_cr;
    logic [3:0]  digit;
    logic [19:0] acc_times_ten;
    logic [16:0] total;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.word  = out_word_reg;

    assign b        = in_ch.word.data_byte;
    assign low      = (b >= hrcd_pkg::CHAR_A && b <= hrcd_pkg::CHAR_Z) ? (b + 8'd32) : b;
    assign is_digit = (b >= hrcd_pkg::CHAR_0 && b <= hrcd_pkg::CHAR_9);
    assign digit    = 4'(b - hrcd_pkg::CHAR_0);

    always_comb
    begin
        logic [1:0]  e_cur;
        logic        f_cur;
        logic        ls_cur;
        logic [3:0]  ni_cur;
        logic        nd_cur;
        logic [1:0]  ph_cur;
        logic [15:0] acc_cur;
        logic [15:0] bc_cur;
        logic [15:0] hs_cur;
        logic [19:0] acc_sum;

        if (in_ch.word.new_request)
        begin
            e_cur   = END_NONE;
            f_cur   = 1'b0;
            ls_cur  = 1'b1;
            ni_cur  = 4'd0;
            nd_cur  = 1'b0;
            ph_cur  = PHASE_NAME;
            acc_cur = 16'd0;
            bc_cur  = 16'd0;
            hs_cur  = 16'd0;
        end
        else
        begin
            e_cur   = end_prog_reg;
            f_cur   = hdr_fin_reg;
            ls_cur  = line_start_reg;
            ni_cur  = name_idx_reg;
            nd_cur  = name_dead_reg;
            ph_cur  = phase_reg;
            acc_cur = len_acc_reg;
            bc_cur  = byte_cnt_reg;
            hs_cur  = hdr_size_reg;
        end

        if (bc_cur != hrcd_pkg::COUNT_MAX)
        begin
            bc_cur = bc_cur + 16'd1;
        end

        acc_times_ten = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0};
        acc_sum       = acc_times_ten + {16'd0, digit};
        prev_cr       = (e_cur == END_CR) || (e_cur == END_CRLFCR);

        end_prog_next   = e_cur;
        hdr_fin_next    = f_cur;
        line_start_next = ls_cur;
        name_idx_next   = ni_cur;
        name_dead_next  = nd_cur;
        phase_next      = ph_cur;
        len_acc_next    = acc_cur;
        byte_cnt_next   = bc_cur;
        hdr_size_next   = hs_cur;

        if (!f_cur)
        begin
            if (ls_cur)
            begin
                name_idx_next  = 4'd0;
                name_dead_next = 1'b0;
            end

            case (ph_cur)
                PHASE_NAME:
                begin
                    if (!name_dead_next)
                    begin
                        if (name_idx_next < hrcd_pkg::NAME_LEN &&
                            low == hrcd_pkg::name_char(name_idx_next))
                        begin
                            if (name_idx_next == hrcd_pkg::NAME_LEN - 4'd1)
                            begin
                                phase_next = PHASE_BLANK;
                            end
                            name_idx_next = name_idx_next + 4'd1;
                        end
                        else
                        begin
                            name_dead_next = 1'b1;
                        end
                    end
                end
                PHASE_BLANK:
                begin
                    if (is_digit)
                    begin
                        len_acc_next = {12'd0, digit};
                        phase_next   = PHASE_DIGIT;
                    end
                    else if (b != hrcd_pkg::CHAR_SP && b != hrcd_pkg::CHAR_TAB)
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
                PHASE_DIGIT:
                begin
                    if (is_digit)
                    begin
                        len_acc_next = (acc_sum > 20'h0FFFF) ? hrcd_pkg::COUNT_MAX
                                                             : acc_sum[15:0];
                    end
                    else
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
                default:
                begin
                    phase_next = ph_cur;
                end
            endcase

            if (e_cur == END_CRLFCR && b == hrcd_pkg::CHAR_LF)
            begin
                hdr_fin_next  = 1'b1;
                hdr_size_next = bc_cur;
                end_prog_next = END_NONE;
            end
            else if (b == hrcd_pkg::CHAR_CR)
            begin
                end_prog_next = (e_cur == END_CRLF) ? END_CRLFCR : END_CR;
            end
            else if (b == hrcd_pkg::CHAR_LF && e_cur == END_CR)
            begin
                end_prog_next = END_CRLF;
            end
            else
            begin
                end_prog_next = END_NONE;
            end

            line_start_next = prev_cr && (b == hrcd_pkg::CHAR_LF);
        end

        total = {1'b0, hdr_size_next} + {1'b0, len_acc_next};

        out_word_next.header_done      = hdr_fin_next;
        out_word_next.request_complete = hdr_fin_next && ({1'b0, byte_cnt_next} >= total);
        out_word_next.body_length      = len_acc_next;
        out_word_next.header_length    = hdr_size_next;
        out_word_next.bytes_seen       = byte_cnt_next;
        out_word_next.overflow         = (byte_cnt_next >= capacity_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAPACITY_RESET;
            end_prog_reg   <= END_NONE;
            hdr_fin_reg    <= 1'b0;
            line_start_reg <= 1'b1;
            name_idx_reg   <= 4'd0;
            name_dead_reg  <= 1'b0;
            phase_reg      <= PHASE_NAME;
            len_acc_reg    <= 16'd0;
            byte_cnt_reg   <= 16'd0;
            hdr_size_reg   <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                end_prog_reg   <= end_prog_next;
                hdr_fin_reg    <= hdr_fin_next;
                line_start_reg <= line_start_next;
                name_idx_reg   <= name_idx_next;
                name_dead_reg  <= name_dead_next;
                phase_reg      <= phase_next;
                len_acc_reg    <= len_acc_next;
                byte_cnt_reg   <= byte_cnt_next;
                hdr_size_reg   <= hdr_size_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire
